>>> hdl/utfhx_pkg.sv
// utfhx_pkg: shared item types, constants and hex spelling helper
// used by every module of the utf8_to_utf16be_hex block; no dependencies
`timescale 1ns / 1ps

package utfhx_pkg;

    localparam logic [20:0] CP_SUPP  = 21'h10000;
    localparam logic [15:0] HI_BASE  = 16'hD800;
    localparam logic [15:0] LO_BASE  = 16'hDC00;
    localparam logic [6:0]  ASCII_0  = 7'h30;
    localparam logic [6:0]  ASCII_A  = 7'h41;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       string_end;
    } t_in;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [6:0]  hex_digit_3;
        logic [6:0]  hex_digit_2;
        logic [6:0]  hex_digit_1;
        logic [6:0]  hex_digit_0;
        logic        last_unit;
    } t_out;

    // up to two result items produced by one input item
    typedef struct packed {
        logic [1:0] cnt;
        t_out       item0;
        t_out       item1;
    } t_pair;

    function automatic logic [6:0] hex_ascii(input logic [3:0] nib);
        logic [6:0] r;
        if (nib < 4'd10) begin
            r = ASCII_0 + {3'b000, nib};
        end else begin
            r = ASCII_A + {3'b000, nib - 4'd10};
        end
        return r;
    endfunction

    function automatic t_out make_item(input logic [15:0] unit, input logic last);
        t_out r;
        r.code_unit   = unit;
        r.hex_digit_3 = hex_ascii(unit[15:12]);
        r.hex_digit_2 = hex_ascii(unit[11:8]);
        r.hex_digit_1 = hex_ascii(unit[7:4]);
        r.hex_digit_0 = hex_ascii(unit[3:0]);
        r.last_unit   = last;
        return r;
    endfunction

endpackage

>>> hdl/utf8_to_utf16be_hex.sv
// utf8_to_utf16be_hex: utf-8 byte stream to utf-16be code units with hex digits
// path: input register, combinational decode, then the result register
// throughput: one byte per cycle while output is ready; a byte giving a surrogate
// pair or an interrupted lead plus a byte holds the input while its second unit waits
// reset: synchronous active low, clears sequence state and all valids
// depends on utfhx_pkg, utfhx_decode, utfhx_outbuf
`timescale 1ns / 1ps

module utf8_to_utf16be_hex (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  utfhx_pkg::t_in  i_in_data,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output utfhx_pkg::t_out o_out_data,
    input  logic            i_out_ready
);
    import utfhx_pkg::*;

    logic  r_in_vld;
    t_in   r_in;
    t_pair pair;
    logic  adv;
    logic  free;

    assign adv        = r_in_vld && ((pair.cnt == 2'd0) || free);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    utfhx_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (r_in),
        .i_adv   (adv),
        .o_pair  (pair)
    );

    utfhx_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && (pair.cnt != 2'd0)),
        .i_pair  (pair),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_free  (free)
    );

`ifndef SYNTHESIS
    a_pair_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && pair.cnt == 2'd2) |->
            (!pair.item0.last_unit && pair.item1.last_unit))
        else $error("pair last flags wrong");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !adv) |=> (r_in_vld && $stable(r_in)))
        else $error("input register lost item");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && o_out_valid))
        else $error("input stalled with no pending result");
`endif

endmodule

>>> hdl/utfhx_decode.sv
// utfhx_decode: utf-8 sequence state and per-byte decode into utf-16 units
// depends on utfhx_pkg
`timescale 1ns / 1ps

module utfhx_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  utfhx_pkg::t_in   i_in,
    input  logic             i_adv,
    output utfhx_pkg::t_pair o_pair
);
    import utfhx_pkg::*;

    logic [20:0] r_pc,   n_pc;
    logic [1:0]  r_pend, n_pend;
    logic [7:0]  r_lead, n_lead;

    logic [7:0]  b;
    logic        s_end;
    logic        cont;
    logic        f_lead;
    logic        f_emit;
    logic [20:0] f_pc;
    logic [1:0]  f_pend;
    logic [20:0] cp;
    logic [20:0] off;
    logic        supp;
    logic [15:0] u0, u1;
    logic [1:0]  cnt;

    assign b      = i_in.byte_in;
    assign s_end  = i_in.string_end;
    assign cont   = (b[7:6] == 2'b10);
    assign f_lead = (b >= 8'hC0) && (b < 8'hF8);
    assign f_emit = !f_lead || s_end;
    assign cp     = {r_pc[14:0], b[5:0]};
    assign supp   = |cp[20:16];
    assign off    = cp - CP_SUPP;

    // state left by a byte handled with nothing pending
    always_comb begin
        f_pc   = '0;
        f_pend = 2'd0;
        if (f_lead && !s_end) begin
            if (!b[5]) begin
                f_pc   = {16'd0, b[4:0]};
                f_pend = 2'd1;
            end else if (!b[4]) begin
                f_pc   = {17'd0, b[3:0]};
                f_pend = 2'd2;
            end else begin
                f_pc   = {18'd0, b[2:0]};
                f_pend = 2'd3;
            end
        end
    end

    always_comb begin
        n_pc   = r_pc;
        n_pend = r_pend;
        n_lead = r_lead;
        u0     = '0;
        u1     = '0;
        cnt    = 2'd0;
        if (r_pend == 2'd0) begin
            n_pc   = f_pc;
            n_pend = f_pend;
            if (f_lead) begin
                n_lead = b;
            end
            if (f_emit) begin
                u0  = {8'h00, b};
                cnt = 2'd1;
            end
        end else if (cont) begin
            n_pc   = cp;
            n_pend = r_pend - 2'd1;
            if (r_pend == 2'd1) begin
                n_pc = '0;
                if (supp) begin
                    u0  = HI_BASE + {5'd0, off[20:10]};
                    u1  = LO_BASE + {6'd0, off[9:0]};
                    cnt = 2'd2;
                end else begin
                    u0  = cp[15:0];
                    cnt = 2'd1;
                end
            end else if (s_end) begin
                u0     = {8'h00, r_lead};
                cnt    = 2'd1;
                n_pc   = '0;
                n_pend = 2'd0;
            end
        end else begin
            // interrupted sequence: lead byte first, then the new byte afresh
            u0     = {8'h00, r_lead};
            cnt    = 2'd1;
            n_pc   = f_pc;
            n_pend = f_pend;
            if (f_lead) begin
                n_lead = b;
            end
            if (f_emit) begin
                u1  = {8'h00, b};
                cnt = 2'd2;
            end
        end
    end

    always_comb begin
        o_pair.cnt   = cnt;
        o_pair.item0 = make_item(u0, cnt == 2'd1);
        o_pair.item1 = make_item(u1, 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_pend <= 2'd0;
            r_lead <= '0;
        end else if (i_adv) begin
            r_pc   <= n_pc;
            r_pend <= n_pend;
            r_lead <= n_lead;
        end
    end

endmodule

>>> hdl/utfhx_outbuf.sv
// utfhx_outbuf: result register holding up to two items of one input byte
// depends on utfhx_pkg
`timescale 1ns / 1ps

module utfhx_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  utfhx_pkg::t_pair i_pair,
    input  logic             i_ready,
    output logic             o_valid,
    output utfhx_pkg::t_out  o_data,
    output logic             o_free
);
    import utfhx_pkg::*;

    logic r_vld;
    logic r_two;
    t_out r_q0;
    t_out r_q1;

    assign o_valid = r_vld;
    assign o_data  = r_q0;
    assign o_free  = !r_vld || (i_ready && !r_two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_two <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_two <= (i_pair.cnt == 2'd2);
        end else if (r_vld && i_ready) begin
            r_vld <= r_two;
            r_two <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q0 <= i_pair.item0;
            r_q1 <= i_pair.item1;
        end else if (r_vld && i_ready && r_two) begin
            r_q0 <= r_q1;
        end
    end

endmodule

>>> tb/sv/testbench.sv
// testbench for utf8_to_utf16be_hex: drives utf-8 byte items, predicts utf-16be units
// with their hex spelling and checks every result item in order; depends on utfhx_pkg
`timescale 1ns / 1ps

module testbench;
    import utfhx_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_in  i_in_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;
    logic i_out_ready = 1'b0;

    t_in         byte_q[$];
    t_out        unit_q[$];
    logic [15:0] units_now[$];

    logic [20:0] cp_acc = '0;
    logic [1:0]  cont_left = '0;
    logic [7:0]  lead = '0;

    t_out want;
    int   mismatch_cnt = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    bit   calm = 1'b0;

    utf8_to_utf16be_hex uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib > 4'd9) begin
            c = 7'd55 + 7'(nib);
        end else begin
            c = 7'd48 + 7'(nib);
        end
        return c;
    endfunction

    function automatic t_out spell_unit(input logic [15:0] u);
        t_out r;
        r.code_unit   = u;
        r.hex_digit_3 = hex_char(u[15:12]);
        r.hex_digit_2 = hex_char(u[11:8]);
        r.hex_digit_1 = hex_char(u[7:4]);
        r.hex_digit_0 = hex_char(u[3:0]);
        r.last_unit   = 1'b0;
        return r;
    endfunction

    // byte seen with no sequence open
    task automatic take_fresh(input logic [7:0] b, input logic fin);
        if (b < 8'hC0 || b >= 8'hF8) begin
            units_now.push_back({8'h00, b});
        end else begin
            lead = b;
            if (b < 8'hE0) begin
                cp_acc = {16'h0000, b[4:0]};
                cont_left = 2'd1;
            end else if (b < 8'hF0) begin
                cp_acc = {17'h00000, b[3:0]};
                cont_left = 2'd2;
            end else begin
                cp_acc = {18'h00000, b[2:0]};
                cont_left = 2'd3;
            end
            if (fin) begin
                units_now.push_back({8'h00, lead});
                cp_acc = '0;
                cont_left = '0;
            end
        end
    endtask

    task automatic predict_units(input t_in it);
        logic [20:0] ofs;
        t_out        r;
        int          i;
        units_now.delete();
        if (cont_left == 2'd0) begin
            take_fresh(it.byte_in, it.string_end);
        end else if (it.byte_in[7:6] == 2'b10) begin
            cp_acc = {cp_acc[14:0], it.byte_in[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                if (cp_acc >= CP_SUPP) begin
                    ofs = cp_acc - CP_SUPP;
                    units_now.push_back(HI_BASE + 16'(ofs[20:10]));
                    units_now.push_back(LO_BASE + 16'(ofs[9:0]));
                end else begin
                    units_now.push_back(cp_acc[15:0]);
                end
                cp_acc = '0;
            end else if (it.string_end) begin
                units_now.push_back({8'h00, lead});
                cp_acc = '0;
                cont_left = '0;
            end
        end else begin
            // sequence cut short: lead goes out alone, then the new byte
            units_now.push_back({8'h00, lead});
            cp_acc = '0;
            cont_left = '0;
            take_fresh(it.byte_in, it.string_end);
        end
        for (i = 0; i < units_now.size(); i++) begin
            r = spell_unit(units_now[i]);
            r.last_unit = (i == units_now.size() - 1);
            unit_q.push_back(r);
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            mismatch_cnt++;
            $display("%0t: %s expected %h got %h", $time, what, want_v, got_v);
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        t_in it;
        it.byte_in = b;
        it.string_end = fin;
        byte_q.push_back(it);
    endtask

    // mostly well-formed characters, some cut short, some raw noise
    task automatic queue_random(input int n);
        int          added;
        int          kind;
        int          len;
        int          keep;
        int          k;
        logic [7:0]  b;
        logic        fin;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(0, 19);
            len = $urandom_range(1, 4);
            keep = len;
            if (kind >= 17) begin
                queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
                added++;
            end else begin
                if (kind >= 14) begin
                    keep = $urandom_range(1, len);
                end
                for (k = 0; k < keep; k++) begin
                    if (k == 0) begin
                        case (len)
                            1: begin
                                b = 8'($urandom_range(0, 127));
                            end
                            2: begin
                                b = 8'hC0 + 8'($urandom_range(0, 31));
                            end
                            3: begin
                                b = 8'hE0 + 8'($urandom_range(0, 15));
                            end
                            default: begin
                                b = 8'hF0 + 8'($urandom_range(0, 7));
                            end
                        endcase
                    end else begin
                        b = 8'h80 + 8'($urandom_range(0, 63));
                    end
                    if (k == keep - 1) begin
                        fin = ($urandom_range(0, 7) == 0);
                    end else begin
                        fin = ($urandom_range(0, 39) == 0);
                    end
                    queue_byte(b, fin);
                    added++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (byte_q.size() != 0 || i_in_valid || unit_q.size() != 0);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= byte_q.pop_front();
                if (!calm && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 9);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_units(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                if (unit_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected result, expected none got unit %h",
                             $time, o_out_data.code_unit);
                end else begin
                    want = unit_q.pop_front();
                    check_field("code_unit", want.code_unit, o_out_data.code_unit);
                    check_field("hex_digit_3", 16'(want.hex_digit_3), 16'(o_out_data.hex_digit_3));
                    check_field("hex_digit_2", 16'(want.hex_digit_2), 16'(o_out_data.hex_digit_2));
                    check_field("hex_digit_1", 16'(want.hex_digit_1), 16'(o_out_data.hex_digit_1));
                    check_field("hex_digit_0", 16'(want.hex_digit_0), 16'(o_out_data.hex_digit_0));
                    check_field("last_unit", 16'(want.last_unit), 16'(o_out_data.last_unit));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 8);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        // ascii extremes
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        // two, three and four byte forms
        queue_byte(8'hC2, 1'b0);
        queue_byte(8'hA9, 1'b0);
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b0);
        queue_byte(8'hAC, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h9F, 1'b0);
        queue_byte(8'h98, 1'b0);
        queue_byte(8'h80, 1'b0);
        // largest code point the encoding can hold
        queue_byte(8'hF7, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b1);
        // stray continuations and invalid leads
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hF8, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // overlong null
        queue_byte(8'hC0, 1'b0);
        queue_byte(8'h80, 1'b0);
        // interrupted by ascii, then by a new lead that ends the string
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'hE1, 1'b0);
        queue_byte(8'hC3, 1'b1);
        // open sequence at string end, interrupted by an invalid lead
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b1);
        queue_byte(8'hF4, 1'b0);
        queue_byte(8'hFE, 1'b1);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        @(negedge i_clk);
        queue_random(900);
        wait_drained();
        calm = 1'b1;
        queue_random(300);
        wait_drained();
        repeat (20) @(negedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/utfhx_pkg.sv
hdl/utfhx_decode.sv
hdl/utfhx_outbuf.sv
hdl/utf8_to_utf16be_hex.sv
tb/sv/testbench.sv
